### src/cdsm_pkg.sv
// Shared constants and widths for the color distance soft mask block.
package cdsm_pkg;

    localparam int CHAN_W      = 8;
    localparam int NUM_LANES   = 4;
    localparam int SQ_W        = 2 * CHAN_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int RAD_W       = 9;
    localparam int CNT_W       = 3;
    localparam int FRAC_BITS   = 8;
    localparam int RAD_F_W     = RAD_W + FRAC_BITS;
    localparam int RADICAND_W  = SUM_W + 2 * FRAC_BITS;
    localparam int ROOT_W      = RADICAND_W / 2;
    localparam int REM_W       = ROOT_W + 2;
    localparam int WEIGHT_W    = 16;
    localparam int DEF_MAX_CHANNELS = 4;

    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 16'h8000;

    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [2:0] REG_AIM_RED       = 3'd1;
    localparam logic [2:0] REG_AIM_GREEN     = 3'd2;
    localparam logic [2:0] REG_AIM_BLUE      = 3'd3;
    localparam logic [2:0] REG_AIM_ALPHA     = 3'd4;
    localparam logic [2:0] REG_RADIUS        = 3'd5;

    localparam logic [CNT_W-1:0] CHANNEL_COUNT_RST = 3'd3;
    localparam logic [RAD_W-1:0] RADIUS_RST        = 9'd64;

endpackage

### src/cdsm_sumsq.sv
// Squared channel differences and their sum, two register stages.
module cdsm_sumsq #(
    parameter int MAX_CHANNELS = cdsm_pkg::DEF_MAX_CHANNELS
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  logic [cdsm_pkg::NUM_LANES-1:0][cdsm_pkg::CHAN_W-1:0] pix,
    input  logic [cdsm_pkg::NUM_LANES-1:0][cdsm_pkg::CHAN_W-1:0] aim,
    input  logic [cdsm_pkg::CNT_W-1:0]                    channel_count,
    output logic                                          out_valid,
    output logic [cdsm_pkg::SUM_W-1:0]                    sum
);

    localparam logic [cdsm_pkg::CNT_W-1:0] MAX_CNT = cdsm_pkg::CNT_W'(MAX_CHANNELS);

    logic [cdsm_pkg::CNT_W-1:0] active;
    logic [cdsm_pkg::NUM_LANES-1:0][cdsm_pkg::SQ_W-1:0] sq_next, sq_reg;
    logic                        v1_reg, v2_reg;
    logic [cdsm_pkg::SUM_W-1:0]  sum_next, sum_reg;

    assign active = (channel_count > MAX_CNT) ? MAX_CNT : channel_count;

    always_comb begin
        for (int k = 0; k < cdsm_pkg::NUM_LANES; k++) begin
            logic [cdsm_pkg::CHAN_W-1:0] d;
            d = (pix[k] > aim[k]) ? pix[k] - aim[k] : aim[k] - pix[k];
            if (cdsm_pkg::CNT_W'(k) < active) begin
                sq_next[k] = d * d;
            end else begin
                sq_next[k] = '0;
            end
        end
    end

    assign sum_next = cdsm_pkg::SUM_W'(sq_reg[0]) + cdsm_pkg::SUM_W'(sq_reg[1])
                    + cdsm_pkg::SUM_W'(sq_reg[2]) + cdsm_pkg::SUM_W'(sq_reg[3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            sq_reg  <= sq_next;
            sum_reg <= sum_next;
        end
    end

    assign out_valid = v2_reg;
    assign sum       = sum_reg;

endmodule

### src/cdsm_sqrt.sv
// Pipelined digit-by-digit square root of sum << 16, one root bit per stage.
module cdsm_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [cdsm_pkg::SUM_W-1:0]   sum,
    output logic                         out_valid,
    output logic [cdsm_pkg::ROOT_W-1:0]  root
);

    localparam int N  = cdsm_pkg::ROOT_W;
    localparam int RW = cdsm_pkg::REM_W;
    localparam int VW = cdsm_pkg::RADICAND_W;

    logic          v_reg    [1:N];
    logic [RW-1:0] rem_reg  [1:N];
    logic [N-1:0]  root_reg [1:N];
    logic [VW-1:0] rad_reg  [1:N];

    for (genvar i = 0; i < N; i++) begin : g_step
        logic          v_in;
        logic [RW-1:0] rem_in;
        logic [N-1:0]  root_in;
        logic [VW-1:0] rad_in;
        logic [RW+1:0] rem_sh;
        logic [RW+1:0] trial;
        logic          take;

        // stage zero takes the input itself
        if (i == 0) begin : g_head
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = {sum, {(2 * cdsm_pkg::FRAC_BITS){1'b0}}};
        end else begin : g_tail
            assign v_in    = v_reg[i];
            assign rem_in  = rem_reg[i];
            assign root_in = root_reg[i];
            assign rad_in  = rad_reg[i];
        end

        assign rem_sh = {rem_in, rad_in[VW-1 -: 2]};
        assign trial  = (RW + 2)'({root_in, 2'b01});
        assign take   = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_in;
            end
            if (en) begin
                rem_reg[i+1]  <= take ? RW'(rem_sh - trial) : RW'(rem_sh);
                root_reg[i+1] <= {root_in[N-2:0], take};
                rad_reg[i+1]  <= {rad_in[VW-3:0], 2'b00};
            end
        end
    end

    assign out_valid = v_reg[N];
    assign root      = root_reg[N];

endmodule

### src/cdsm_div.sv
// Clamp against the radius and form the Q1.15 weight by restoring division.
module cdsm_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [cdsm_pkg::ROOT_W-1:0]    distance,
    input  logic [cdsm_pkg::RAD_W-1:0]     radius,
    output logic                           out_valid,
    output logic [cdsm_pkg::WEIGHT_W-1:0]  weight
);

    localparam int N  = cdsm_pkg::WEIGHT_W;
    localparam int FW = cdsm_pkg::RAD_F_W;

    logic [FW-1:0] rf;
    assign rf = {radius, {cdsm_pkg::FRAC_BITS{1'b0}}};

    logic          v_reg   [1:N];
    logic [FW:0]   r_reg   [1:N];
    logic [N-1:0]  q_reg   [1:N];
    logic          zr_reg  [1:N];
    logic          hit_reg [1:N];

    logic [FW-1:0] dclamp;
    logic          vc_reg, zrc_reg, hitc_reg;
    logic [FW:0]   rc_reg;

    assign dclamp = (FW'(distance) > rf) ? rf : FW'(distance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= in_valid;
        end
        if (en) begin
            rc_reg   <= (FW + 1)'(rf - dclamp);
            zrc_reg  <= (rf == '0);
            hitc_reg <= (distance == '0);
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic          v_in;
        logic [FW:0]   r_in;
        logic [N-1:0]  q_in;
        logic          zr_in;
        logic          hit_in;
        logic          ge;
        logic [FW:0]   rem;

        if (i == 0) begin : g_head
            assign v_in   = vc_reg;
            assign r_in   = rc_reg;
            assign q_in   = '0;
            assign zr_in  = zrc_reg;
            assign hit_in = hitc_reg;
        end else begin : g_tail
            assign v_in   = v_reg[i];
            assign r_in   = r_reg[i];
            assign q_in   = q_reg[i];
            assign zr_in  = zr_reg[i];
            assign hit_in = hit_reg[i];
        end

        assign ge  = r_in >= (FW + 1)'(rf);
        assign rem = ge ? r_in - (FW + 1)'(rf) : r_in;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_in;
            end
            if (en) begin
                // remainder stays below rf, so doubling fits
                r_reg[i+1]   <= {rem[FW-1:0], 1'b0};
                q_reg[i+1]   <= {q_in[N-2:0], ge};
                zr_reg[i+1]  <= zr_in;
                hit_reg[i+1] <= hit_in;
            end
        end
    end

    assign out_valid = v_reg[N];
    assign weight    = zr_reg[N] ? (hit_reg[N] ? cdsm_pkg::FULL_WEIGHT : '0) : q_reg[N];

endmodule

### src/color_distance_soft_mask.sv
// Soft color-key weight: Euclidean distance to an aim color mapped to Q1.15.
//
// Usage: pixels enter on the s_ channel (s_valid/s_ready, four 8-bit
// channel samples) and one weight per pixel leaves on the m_ channel
// (m_valid/m_ready, 16-bit Q1.15, 32768 = full selection). Results come
// out in input order.
// Throughput: one pixel per clock while the output is not stalled. Stages
// from acceptance to m_valid: 2 sum-of-squares stages, 17 square-root stages,
// 1 clamp stage, 16 division stages, 1 output register; the root and quotient
// loops each resolve one bit per stage.
// When m_ready is low while a result is held, the whole pipeline holds,
// bubbles included, and s_ready drops; nothing is lost or repeated.
// Configuration is through the APB port (channel_count, aim_red..aim_alpha,
// radius at byte addresses 0..20); write it only while the pipeline is
// empty. Reset empties the pipeline and loads channel_count 3, aim 0 and
// radius 64.
module color_distance_soft_mask #(
    parameter int MAX_CHANNELS = cdsm_pkg::DEF_MAX_CHANNELS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_chan_zero,
    input  logic [7:0]  s_chan_one,
    input  logic [7:0]  s_chan_two,
    input  logic [7:0]  s_chan_three,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_weight
);

    logic [cdsm_pkg::CNT_W-1:0] channel_count_reg;
    logic [cdsm_pkg::NUM_LANES-1:0][cdsm_pkg::CHAN_W-1:0] aim_reg;
    logic [cdsm_pkg::RAD_W-1:0] radius_reg;
    logic [2:0]                 reg_idx;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= cdsm_pkg::CHANNEL_COUNT_RST;
            aim_reg           <= '0;
            radius_reg        <= cdsm_pkg::RADIUS_RST;
        end else if (wr_en) begin
            case (reg_idx)
                cdsm_pkg::REG_CHANNEL_COUNT: channel_count_reg <= pwdata[2:0];
                cdsm_pkg::REG_AIM_RED:       aim_reg[0] <= pwdata[7:0];
                cdsm_pkg::REG_AIM_GREEN:     aim_reg[1] <= pwdata[7:0];
                cdsm_pkg::REG_AIM_BLUE:      aim_reg[2] <= pwdata[7:0];
                cdsm_pkg::REG_AIM_ALPHA:     aim_reg[3] <= pwdata[7:0];
                cdsm_pkg::REG_RADIUS:        radius_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cdsm_pkg::REG_CHANNEL_COUNT: prdata = 32'(channel_count_reg);
            cdsm_pkg::REG_AIM_RED:       prdata = 32'(aim_reg[0]);
            cdsm_pkg::REG_AIM_GREEN:     prdata = 32'(aim_reg[1]);
            cdsm_pkg::REG_AIM_BLUE:      prdata = 32'(aim_reg[2]);
            cdsm_pkg::REG_AIM_ALPHA:     prdata = 32'(aim_reg[3]);
            cdsm_pkg::REG_RADIUS:        prdata = 32'(radius_reg);
            default:                     prdata = '0;
        endcase
    end

    // advance everything unless a held result is not taken
    logic en;
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    logic [cdsm_pkg::NUM_LANES-1:0][cdsm_pkg::CHAN_W-1:0] pix;
    assign pix = {s_chan_three, s_chan_two, s_chan_one, s_chan_zero};

    logic                          sum_valid, root_valid, wt_valid;
    logic [cdsm_pkg::SUM_W-1:0]    sum;
    logic [cdsm_pkg::ROOT_W-1:0]   root;
    logic [cdsm_pkg::WEIGHT_W-1:0] wt;

    cdsm_sumsq #(.MAX_CHANNELS(MAX_CHANNELS)) u_sumsq (
        .aclk, .aresetn, .en,
        .in_valid      (s_valid),
        .pix           (pix),
        .aim           (aim_reg),
        .channel_count (channel_count_reg),
        .out_valid     (sum_valid),
        .sum           (sum)
    );

    cdsm_sqrt u_sqrt (
        .aclk, .aresetn, .en,
        .in_valid  (sum_valid),
        .sum       (sum),
        .out_valid (root_valid),
        .root      (root)
    );

    cdsm_div u_div (
        .aclk, .aresetn, .en,
        .in_valid  (root_valid),
        .distance  (root),
        .radius    (radius_reg),
        .out_valid (wt_valid),
        .weight    (wt)
    );

    logic                          m_valid_reg;
    logic [cdsm_pkg::WEIGHT_W-1:0] m_weight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= wt_valid;
        end
        if (en) begin
            m_weight_reg <= wt;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_weight = m_weight_reg;

endmodule

### bench/color_distance_soft_mask_test.sv
// Self-checking bench for the color distance soft mask block.
module color_distance_soft_mask_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT = 40;

    class weight_scoreboard;
        logic [2:0]  chan_cnt;
        logic [7:0]  aim [4];
        logic [8:0]  rad;
        logic [15:0] pending_weights [$];
        int errors;
        int checked;

        function void clear();
            chan_cnt = cdsm_pkg::CHANNEL_COUNT_RST;
            for (int k = 0; k < 4; k++) aim[k] = 8'd0;
            rad = cdsm_pkg::RADIUS_RST;
            pending_weights.delete();
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                cdsm_pkg::REG_CHANNEL_COUNT: chan_cnt = val[2:0];
                cdsm_pkg::REG_AIM_RED:       aim[0] = val[7:0];
                cdsm_pkg::REG_AIM_GREEN:     aim[1] = val[7:0];
                cdsm_pkg::REG_AIM_BLUE:      aim[2] = val[7:0];
                cdsm_pkg::REG_AIM_ALPHA:     aim[3] = val[7:0];
                cdsm_pkg::REG_RADIUS:        rad = val[8:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] root_floor(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_pixel(logic [7:0] px [4]);
            int n;
            logic [63:0] sq_sum;
            logic [63:0] root_val;
            logic [63:0] rf;
            logic [63:0] d;
            logic [63:0] w;
            n = (chan_cnt > 4) ? 4 : chan_cnt;
            sq_sum = 0;
            for (int k = 0; k < n; k++) begin
                d = (px[k] > aim[k]) ? px[k] - aim[k] : aim[k] - px[k];
                sq_sum = sq_sum + d * d;
            end
            root_val = root_floor(sq_sum << 16);
            rf = {55'd0, rad} << 8;
            if (rf == 0) begin
                w = (root_val == 0) ? 64'd32768 : 64'd0;
            end else begin
                if (root_val > rf) root_val = rf;
                w = ((rf - root_val) * 32768) / rf;
            end
            pending_weights.push_back(w[15:0]);
        endfunction

        function void check_weight(logic [15:0] got);
            logic [15:0] want;
            checked++;
            if (pending_weights.size() == 0) begin
                $display("%t: weight %0d arrived with nothing pending", $time, got);
                errors++;
                return;
            end
            want = pending_weights.pop_front();
            if (got !== want) begin
                $display("%t: weight expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_chan_zero, s_chan_one, s_chan_two, s_chan_three;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_weight;

    weight_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int hold_off_cycles;

    color_distance_soft_mask i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_chan_zero(s_chan_zero), .s_chan_one(s_chan_one),
        .s_chan_two(s_chan_two), .s_chan_three(s_chan_three),
        .m_valid(m_valid), .m_ready(m_ready), .m_weight(m_weight)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_weight(m_weight);
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Send one pixel request; valid stays up across back-to-back pixels.
    task automatic send_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                              logic [7:0] c3);
        logic [7:0] px [4];
        px[0] = c0; px[1] = c1; px[2] = c2; px[3] = c3;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_chan_zero <= c0;
        s_chan_one <= c1;
        s_chan_two <= c2;
        s_chan_three <= c3;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(px);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_weights.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT) @(posedge aclk);
    endtask

    // Mostly pixels near the aim color so weights land inside the radius.
    task automatic random_burst(int n);
        logic [7:0] c [4];
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(3) != 0)
                    c[k] = sb.aim[k] + 8'($urandom_range(60)) - 8'd30;
                else
                    c[k] = 8'($urandom);
            end
            send_pixel(c[0], c[1], c[2], c[3]);
        end
    endtask

    task automatic random_setting();
        reg_write(cdsm_pkg::REG_CHANNEL_COUNT, 32'($urandom_range(7)));
        reg_write(cdsm_pkg::REG_AIM_RED, $urandom);
        reg_write(cdsm_pkg::REG_AIM_GREEN, $urandom);
        reg_write(cdsm_pkg::REG_AIM_BLUE, $urandom);
        reg_write(cdsm_pkg::REG_AIM_ALPHA, $urandom);
        reg_write(cdsm_pkg::REG_RADIUS,
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(90));
    endtask

    initial begin
        sb = new();
        sb.clear();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_cycles = 0;
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0;
        s_chan_zero = '0; s_chan_one = '0; s_chan_two = '0; s_chan_three = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings, then extremes of the channel count and radius registers.
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd30, 8'd20, 8'd10, 8'd200);
        drain();
        reg_write(cdsm_pkg::REG_CHANNEL_COUNT, 32'd4);
        reg_write(cdsm_pkg::REG_AIM_RED, 32'd255);
        reg_write(cdsm_pkg::REG_AIM_GREEN, 32'd0);
        reg_write(cdsm_pkg::REG_AIM_BLUE, 32'd128);
        reg_write(cdsm_pkg::REG_AIM_ALPHA, 32'd1);
        reg_write(cdsm_pkg::REG_RADIUS, 32'd511);
        send_pixel(8'd255, 8'd0, 8'd128, 8'd1);
        send_pixel(8'd0, 8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd255, 8'd0);
        send_pixel(8'd254, 8'd1, 8'd129, 8'd0);
        drain();
        reg_write(cdsm_pkg::REG_RADIUS, 32'd0);
        send_pixel(8'd255, 8'd0, 8'd128, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd128, 8'd2);
        drain();
        reg_write(cdsm_pkg::REG_RADIUS, 32'd1);
        reg_write(cdsm_pkg::REG_CHANNEL_COUNT, 32'd0);
        send_pixel(8'd0, 8'd255, 8'd0, 8'd255);
        drain();
        reg_write(cdsm_pkg::REG_CHANNEL_COUNT, 32'd7);
        send_pixel(8'd255, 8'd0, 8'd128, 8'd0);
        send_pixel(8'd255, 8'd1, 8'd128, 8'd1);
        drain();
        reg_write(cdsm_pkg::REG_CHANNEL_COUNT, 32'd5);
        reg_write(cdsm_pkg::REG_RADIUS, 32'd2);
        send_pixel(8'd255, 8'd1, 8'd128, 8'd1);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        drain();
        reg_write(cdsm_pkg::REG_CHANNEL_COUNT, 32'd1);
        send_pixel(8'd254, 8'd0, 8'd0, 8'd0);
        drain();

        // Random phases with different idling mixes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 77; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 77; end
                default: begin send_idle_pct = 25; stall_pct = 25; end
            endcase
            random_setting();
            if (ph == 4) hold_off_cycles = 300;
            random_burst(110);
            drain();
        end
        send_idle_pct = 0;
        stall_pct = 0;
        reg_write(cdsm_pkg::REG_CHANNEL_COUNT, 32'd3);
        reg_write(cdsm_pkg::REG_RADIUS, 32'd64);
        random_burst(20);
        drain();

        $display("Covered %0d weights over eight random register settings,",
                 sb.checked);
        $display("register extremes, and long receiver hold-off.");
        if (sb.errors == 0 && sb.pending_weights.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
